// ----- rtl/lfcd_pkg.sv -----
// Shared constants, types and CRC function for the length-framed CRC16 deframer.
package lfcd_pkg;

    localparam logic [7:0]  HDR_FIRST  = 8'h55;
    localparam logic [7:0]  HDR_SECOND = 8'hAA;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_CRC_GOOD = 2'd1;
    localparam logic [1:0] KIND_CRC_BAD  = 2'd2;

    localparam int RESULT_W = 56;

    typedef struct packed {
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
        logic [7:0]  frame_length;
        logic [7:0]  payload_position;
        logic [7:0]  out_byte;
    } result_t;

    // CRC16-MODBUS, one byte, reflected, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- rtl/length_framed_crc16_deframer.sv -----
// Length-framed CRC16 deframer: 55 AA len payload crc_lo crc_hi.
//
// Input stream s_axis carries one received byte per request. The block hunts
// for the 0x55 0xAA header, takes the length byte, then forwards every payload
// byte at once as a payload request on m_axis with its index and the frame
// length. After the two little-endian CRC bytes it sends one end-of-frame
// request: CRC good or CRC mismatch, with received and computed CRC16-MODBUS
// (init 0xFFFF, poly 0xA001, over payload only). A zero length goes straight
// to the CRC bytes.
// Throughput: one byte per cycle while m_axis does not stall. Each byte is
// registered in the input register and its result then loads into the result
// register; the CRC is a single unrolled byte update
// between the two registers.
// Reset clears the parser to header search and drops any held request.
// When m_axis stalls the result register holds; the input register still
// takes and retires bytes that make no result, and holds a result-making
// byte with s_axis_tready low until the result register frees.
module length_framed_crc16_deframer
    import lfcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [RESULT_W-1:0] m_axis_tdata,   // out_byte, payload_position,
                                                // frame_length, received_crc,
                                                // computed_crc
    output logic [1:0]          m_axis_tuser    // [1:0] out_kind
);

    localparam logic [2:0] PH_HDR1 = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC1 = 3'd4;
    localparam logic [2:0] PH_CRC2 = 3'd5;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg, out_kind_next;
    result_t     out_data_reg, out_data_next;

    logic        produces;
    logic        out_free;
    logic        advance;
    logic [7:0]  count_inc;
    logic [15:0] rx_crc;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign produces      = (phase_reg == PH_DATA) || (phase_reg == PH_CRC2);
    assign advance       = in_valid_reg && (!produces || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    assign count_inc = count_reg + 8'd1;
    assign rx_crc    = {in_byte_reg, crc_lo_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_lo_next   = crc_lo_reg;
        out_kind_next = KIND_PAYLOAD;
        out_data_next = '0;
        unique case (phase_reg)
            PH_HDR2:
            begin
                if (in_byte_reg == HDR_SECOND)
                    phase_next = PH_LEN;
                else if (in_byte_reg == HDR_FIRST)
                    phase_next = PH_HDR2;
                else
                    phase_next = PH_HDR1;
            end
            PH_LEN:
            begin
                length_next = in_byte_reg;
                count_next  = 8'd0;
                crc_next    = CRC_INIT;
                phase_next  = (in_byte_reg == 8'd0) ? PH_CRC1 : PH_DATA;
            end
            PH_DATA:
            begin
                crc_next   = crc16_byte(crc_reg, in_byte_reg);
                count_next = count_inc;
                if (count_inc >= length_reg)
                    phase_next = PH_CRC1;
                out_data_next.out_byte         = in_byte_reg;
                out_data_next.payload_position = count_reg;
                out_data_next.frame_length     = length_reg;
            end
            PH_CRC1:
            begin
                crc_lo_next = in_byte_reg;
                phase_next  = PH_CRC2;
            end
            PH_CRC2:
            begin
                out_kind_next              = (rx_crc == crc_reg) ? KIND_CRC_GOOD
                                                                 : KIND_CRC_BAD;
                out_data_next.frame_length = length_reg;
                out_data_next.received_crc = rx_crc;
                out_data_next.computed_crc = crc_reg;
                phase_next                 = PH_HDR1;
            end
            default:
            begin
                phase_next = (in_byte_reg == HDR_FIRST) ? PH_HDR2 : PH_HDR1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HDR1;
            length_reg    <= 8'd0;
            count_reg     <= 8'd0;
            crc_reg       <= CRC_INIT;
            crc_lo_reg    <= 8'd0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                phase_reg  <= phase_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                crc_reg    <= crc_next;
                crc_lo_reg <= crc_lo_next;
            end
            if (advance && produces)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
        if (advance && produces)
        begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (count_reg < length_reg))
        else $error("payload count reached declared length in data phase");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_PAYLOAD || m_axis_tuser == KIND_CRC_GOOD
                           || m_axis_tuser == KIND_CRC_BAD))
        else $error("illegal result kind");

    a_payload_no_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD) |-> (m_axis_tdata[55:24] == 32'd0))
        else $error("payload request carries CRC fields");

    a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held input byte lost");

endmodule
